// ===== rtl/core/radio_device_presence_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radio device presence table
// Shared helpers so that every checked module writes its properties alike.
// ---------------------------------------------------------------------------
`ifndef RADIO_DEVICE_PRESENCE_TABLE_TOP_DEFINES_SVH
`define RADIO_DEVICE_PRESENCE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RDPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RDPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// rdpt_pkg
// Types and codes shared by the presence table and its entry store.
// ---------------------------------------------------------------------------
package rdpt_pkg;

  // One table entry as it sits in the store.
  typedef struct packed {
    logic [47:0]        address;
    logic               present;
    logic [4:0]         misses;
    logic signed [7:0]  rssi;
    logic [31:0]        cod;
    logic [47:0]        total_time;
    logic [47:0]        last_seen;
    logic [47:0]        first_seen;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // Command codes.
  localparam logic [1:0] CMD_SIGHTING   = 2'd0;
  localparam logic [1:0] CMD_SCAN_START = 2'd1;
  localparam logic [1:0] CMD_SWEEP      = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_KNOWN     = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SWEPT     = 3'd3;
  localparam logic [2:0] ST_READ_OK   = 3'd4;
  localparam logic [2:0] ST_READ_OOR  = 3'd5;

  // Values given to a freshly appended entry, the cap on the miss count and the reset value of miss_limit.
  localparam logic signed [7:0] NEW_RSSI      = -8'sd128;
  localparam logic [31:0]       NEW_COD       = 32'hFFFF_FFFF;
  localparam logic [4:0]        MISS_MAX      = 5'd31;
  localparam logic [3:0]        MISS_LIMIT_RST = 4'd3;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] index;
    entry_t     ent;
    logic [6:0] left_cnt;
    logic [6:0] back_cnt;
  } result_t;

endpackage

// ===== rtl/core/radio_device_presence_table_top.sv =====
// ---------------------------------------------------------------------------
// radio_device_presence_table_top
// Table of radio devices keyed by address, with sighting, scan and read beats.
// ---------------------------------------------------------------------------
// The block takes one command beat at a time and returns exactly one result
// beat for it. All entries live in a single store with one read port and one
// write port. A sighting or a scan end sweep walks the table through that
// read port one entry per cycle; a read looks at one entry and a scan start
// at none. A sighting stops its walk at the entry with its address and then
// writes the updated entry back. A new address walks every filled entry and
// then writes the new entry at the end; a full table drops the sighting
// after its walk. A scan end sweep reads one entry and writes the previous
// one back in each cycle. A result sits in an output register until it is
// taken, and the next command beat is accepted from the cycle after that
// register has been loaded.
// The miss_limit register is written through its own channel, which is
// always ready, and should only be written while no command is in flight.
// The store needs no clearing after reset: only entries below the fill count
// are ever looked at.
module radio_device_presence_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  // Command channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [47:0]        device_address,
  input  logic [47:0]        now_us,
  input  logic               rssi_valid,
  input  logic signed [7:0]  rssi_value,
  input  logic               class_valid,
  input  logic [31:0]        class_value,
  input  logic               marks_present,
  input  logic [5:0]         read_index,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [5:0]         entry_index,
  output logic [47:0]        entry_address,
  output logic               entry_present,
  output logic [4:0]         entry_misses,
  output logic signed [7:0]  entry_rssi,
  output logic [31:0]        entry_class,
  output logic [47:0]        entry_total_time,
  output logic [47:0]        entry_last_seen,
  output logic [47:0]        entry_first_seen,
  output logic [6:0]         left_count,
  output logic [6:0]         returned_count,
  // Configuration channel (miss_limit).
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  `include "radio_device_presence_table_top_defines.svh"

  // Index width of the store and width of a counter that can hold the depth.
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  // Bits of a result behind the status and index fields.
  localparam int unsigned TailW = rdpt_pkg::EntryWidth + 14;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRCH = 6'b000010,
    S_UPD  = 6'b000100,
    S_SWP  = 6'b001000,
    S_RD   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  // Control and architectural state.
  logic [CW-1:0] entry_count;
  logic [47:0]   scan_start;
  logic [3:0]    miss_limit;

  // Walk pointer: p is the next entry to read, rk the entry whose data is
  // arriving this cycle, rv says that data is valid.
  logic [CW-1:0] p;
  logic [IW-1:0] rk;
  logic          rv;

  // Latched command beat.
  logic [47:0]       cur_addr;
  logic [47:0]       cur_now;
  logic              cur_rssi_v;
  logic signed [7:0] cur_rssi;
  logic              cur_cod_v;
  logic [31:0]       cur_cod;
  logic              cur_marks;
  logic [5:0]        cur_ridx;

  // Entry being updated by a sighting.
  rdpt_pkg::entry_t ent;
  logic [47:0]      elapsed;
  logic [IW-1:0]    k;
  logic             found;

  logic [CW-1:0]    left_cnt;
  logic [CW-1:0]    back_cnt;

  rdpt_pkg::result_t res;
  rdpt_pkg::result_t out_r;

  // Store ports.
  logic             st_we;
  logic [IW-1:0]    st_waddr;
  rdpt_pkg::entry_t st_wdata;
  logic [IW-1:0]    st_raddr;
  rdpt_pkg::entry_t st_rdata;

  logic in_beat;
  logic read_in_range;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign read_in_range = (32'(read_index) < 32'(entry_count));

  // A read command addresses the store straight from the port; every walk
  // addresses it from the pointer.
  assign st_raddr = (state == S_IDLE) ? IW'(read_index) : IW'(p);

  // Sighting update of the held entry. Elapsed time only counts while the
  // entry is present.
  rdpt_pkg::entry_t upd_ent;
  always_comb begin
    upd_ent = ent;
    if (ent.present) begin
      upd_ent.total_time = ent.total_time + elapsed;
    end
    upd_ent.last_seen = cur_now;
    if (cur_rssi_v) begin
      upd_ent.rssi = cur_rssi;
    end
    if (cur_cod_v) begin
      upd_ent.cod = cur_cod;
    end
    if (cur_marks) begin
      upd_ent.present = 1'b1;
      upd_ent.misses  = '0;
    end
  end

  // Sweep rule for the entry arriving from the store. An entry that has just
  // gone absent was unseen since the scan start, so it cannot return here.
  rdpt_pkg::entry_t sw_ent;
  logic             sw_left;
  logic             sw_back;
  always_comb begin
    sw_ent  = st_rdata;
    sw_left = 1'b0;
    sw_back = 1'b0;
    if (sw_ent.present && (sw_ent.last_seen < scan_start)) begin
      if (sw_ent.misses != rdpt_pkg::MISS_MAX) begin
        sw_ent.misses = sw_ent.misses + 5'd1;
      end
      sw_ent.present = (sw_ent.misses <= {1'b0, miss_limit});
      sw_left = !sw_ent.present;
    end
    if (!sw_ent.present && (sw_ent.last_seen >= scan_start)) begin
      sw_ent.present = 1'b1;
      sw_ent.misses  = '0;
      sw_back = 1'b1;
    end
  end

  assign st_we    = (state == S_UPD) || ((state == S_SWP) && rv);
  assign st_waddr = (state == S_UPD) ? k : rk;
  assign st_wdata = (state == S_UPD) ? upd_ent : sw_ent;

  rdpt_store #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Payload of the accepted beat.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_addr   <= device_address;
      cur_now    <= now_us;
      cur_rssi_v <= rssi_valid;
      cur_rssi   <= rssi_value;
      cur_cod_v  <= class_valid;
      cur_cod    <= class_value;
      cur_marks  <= marks_present;
      cur_ridx   <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_start  <= '0;
      miss_limit  <= rdpt_pkg::MISS_LIMIT_RST;
      out_valid   <= 1'b0;
      rv          <= 1'b0;
      p           <= '0;
    end else begin
      if (cfg_valid) begin
        miss_limit <= cfg_data;
      end
      // The output register is loaded from the done state, or emptied when
      // its beat is taken.
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            p        <= '0;
            rv       <= 1'b0;
            left_cnt <= '0;
            back_cnt <= '0;
            case (cmd)
              rdpt_pkg::CMD_SIGHTING: begin
                state <= S_SRCH;
              end
              rdpt_pkg::CMD_SCAN_START: begin
                res        <= '0;
                scan_start <= now_us;
                state      <= S_DONE;
              end
              rdpt_pkg::CMD_SWEEP: begin
                state <= S_SWP;
              end
              default: begin
                if (read_in_range) begin
                  state <= S_RD;
                end else begin
                  res   <= {rdpt_pkg::ST_READ_OOR, read_index, {TailW{1'b0}}};
                  state <= S_DONE;
                end
              end
            endcase
          end
        end

        S_SRCH: begin
          if (rv && (st_rdata.address == cur_addr)) begin
            ent     <= st_rdata;
            elapsed <= cur_now - st_rdata.last_seen;
            k       <= rk;
            found   <= 1'b1;
            rv      <= 1'b0;
            state   <= S_UPD;
          end else if (p < entry_count) begin
            rk <= IW'(p);
            rv <= 1'b1;
            p  <= p + CW'(1);
          end else if (rv) begin
            rv <= 1'b0;
          end else if (entry_count == DepthC) begin
            res   <= {rdpt_pkg::ST_FULL, 6'd0, {TailW{1'b0}}};
            state <= S_DONE;
          end else begin
            // Append a new entry at the end of the filled region.
            ent <= '{address: cur_addr, present: 1'b1, misses: '0,
                     rssi: rdpt_pkg::NEW_RSSI, cod: rdpt_pkg::NEW_COD,
                     total_time: '0, last_seen: cur_now, first_seen: cur_now};
            elapsed     <= '0;
            k           <= IW'(entry_count);
            found       <= 1'b0;
            entry_count <= entry_count + CW'(1);
            state       <= S_UPD;
          end
        end

        S_UPD: begin
          res   <= {found ? rdpt_pkg::ST_KNOWN : rdpt_pkg::ST_ADDED, 6'(k), upd_ent,
                    14'd0};
          state <= S_DONE;
        end

        S_SWP: begin
          if (rv) begin
            left_cnt <= left_cnt + CW'(sw_left);
            back_cnt <= back_cnt + CW'(sw_back);
          end
          if (p < entry_count) begin
            rk <= IW'(p);
            rv <= 1'b1;
            p  <= p + CW'(1);
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              res   <= {rdpt_pkg::ST_SWEPT, 6'd0, {rdpt_pkg::EntryWidth{1'b0}},
                        7'(left_cnt), 7'(back_cnt)};
              state <= S_DONE;
            end
          end
        end

        S_RD: begin
          res   <= {rdpt_pkg::ST_READ_OK, cur_ridx, st_rdata, 14'd0};
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_r <= res;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status           = out_r.status;
  assign entry_index      = out_r.index;
  assign entry_address    = out_r.ent.address;
  assign entry_present    = out_r.ent.present;
  assign entry_misses     = out_r.ent.misses;
  assign entry_rssi       = out_r.ent.rssi;
  assign entry_class      = out_r.ent.cod;
  assign entry_total_time = out_r.ent.total_time;
  assign entry_last_seen  = out_r.ent.last_seen;
  assign entry_first_seen = out_r.ent.first_seen;
  assign left_count       = out_r.left_cnt;
  assign returned_count   = out_r.back_cnt;

  // The fill count never runs past the store.
  `RDPT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, entry_count <= DepthC, "entry count overflow")
  // The store is written only by a sighting update or by a sweep write-back.
  `RDPT_ASSERT_NOW(a_write_src, clk, rst, st_we, (state == S_UPD) || (state == S_SWP), "stray store write")
  // A full-table result is only given when the table really is full.
  `RDPT_ASSERT_NOW(a_full_real, clk, rst, out_valid && (status == rdpt_pkg::ST_FULL), entry_count == DepthC, "full status with free entries")
  // An accepted command always leaves the idle state.
  `RDPT_ASSERT_NEXT(a_busy, clk, rst, in_beat, state != S_IDLE, "command beat not taken up")

endmodule

// ===== rtl/core/rdpt_store.sv =====
// ---------------------------------------------------------------------------
// rdpt_store
// Entry store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module rdpt_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  rdpt_pkg::entry_t  wdata,
  input  logic [IW-1:0]     raddr,
  output rdpt_pkg::entry_t  rdata
);

  rdpt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
